>>> rtl/register_access_packet_framer_defines.svh
// Assertion macros shared by the register access packet framer RTL.
// Depends on nothing; the using module must provide clk and rst signals.
`ifndef REGISTER_ACCESS_PACKET_FRAMER_DEFINES_SVH
`define REGISTER_ACCESS_PACKET_FRAMER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RAPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define RAPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/rapf_pkg.sv
// Shared types and codes for the register access packet framer.
// Used by every module of the block; depends on nothing.
package rapf_pkg;

  // Command codes of an incoming request.
  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_PAYLOAD = 2'd2;
  localparam logic [1:0] CMD_RX      = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ADDR = 2'd1;
  localparam logic [1:0] ST_SEQ  = 2'd2;

  localparam logic [7:0] HEADER_RESET = 8'hF0;
  localparam int         WR_BIT       = 7;

  // Job queue between front and back.
  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

  // Steps of a start job: header, unit id, address, count, sum.
  localparam logic [2:0] STEP_HDR  = 3'd0;
  localparam logic [2:0] STEP_UID  = 3'd1;
  localparam logic [2:0] STEP_ADDR = 3'd2;
  localparam logic [2:0] STEP_CNT  = 3'd3;
  localparam logic [2:0] STEP_SUM  = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WRITE,
    PH_READ
  } phase_t;

  typedef enum logic [1:0] {
    JOB_STATUS,
    JOB_START,
    JOB_PAYLOAD,
    JOB_RDATA
  } job_op_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] unit_id;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  // One classified request. The flag means: for a start, a write with a
  // nonzero count (no sum yet); for a payload or read byte, the final byte.
  typedef struct packed {
    job_op_t    op;
    logic [1:0] status;
    logic       flag;
    logic [7:0] hdr;
    logic [7:0] uid;
    logic [7:0] addr;
    logic [7:0] cnt;
    logic [7:0] dat;
  } job_t;

endpackage

>>> rtl/rapf_jobq.sv
// Small first-in first-out queue of classified jobs between front and back.
// Depends on rapf_pkg for the job type and depth.
module rapf_jobq (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  rapf_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output logic          rd_valid,
  output rapf_pkg::job_t rd_job
);

  rapf_pkg::job_t                      slots [rapf_pkg::JOBQ_DEPTH];
  logic [rapf_pkg::JOBQ_PTR_W-1:0]     wr_ptr;
  logic [rapf_pkg::JOBQ_PTR_W-1:0]     rd_ptr;
  logic [rapf_pkg::JOBQ_CNT_W-1:0]     count;
  logic                                do_wr;
  logic                                do_rd;

  assign full     = (count == rapf_pkg::JOBQ_CNT_W'(rapf_pkg::JOBQ_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_job   = slots[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

endmodule

>>> rtl/rapf_front.sv
// Front end: accepts requests, tracks the protocol phase and byte count,
// and turns each request into one job. Depends on rapf_pkg.
module rapf_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  rapf_pkg::in_item_t request,
  input  logic               header_we,
  input  logic [7:0]         header_wdata,
  output logic               q_wr,
  output rapf_pkg::job_t     q_job,
  input  logic               q_full
);

  rapf_pkg::phase_t phase;
  rapf_pkg::phase_t phase_next;
  logic [7:0]       bytes_left;
  logic [7:0]       bytes_left_next;
  logic [7:0]       header_byte;
  logic [7:0]       bl_dec;
  logic             accept;
  logic             is_start;
  logic             is_write;
  logic             cnt_zero;

  assign full     = q_full;
  assign accept   = push && !q_full;
  assign q_wr     = accept;
  assign bl_dec   = bytes_left - 8'd1;
  assign is_write = (request.cmd == rapf_pkg::CMD_WRITE);
  assign cnt_zero = (request.byte_count == 8'd0);

  always_comb begin
    is_start = request.cmd inside {rapf_pkg::CMD_WRITE, rapf_pkg::CMD_READ};
  end

  // Header register; the user must write it only while the block is idle, as the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= rapf_pkg::HEADER_RESET;
    end else if (header_we) begin
      header_byte <= header_wdata;
    end
  end

  // Phase and remaining byte count.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= rapf_pkg::PH_IDLE;
      bytes_left <= 8'd0;
    end else if (accept) begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
    end
  end

  // Next state of the phase machine.
  always_comb begin
    phase_next      = phase;
    bytes_left_next = bytes_left;
    case (request.cmd)
      rapf_pkg::CMD_WRITE, rapf_pkg::CMD_READ: begin
        if (phase == rapf_pkg::PH_IDLE && !request.reg_addr[rapf_pkg::WR_BIT]) begin
          bytes_left_next = request.byte_count;
          if (cnt_zero) begin
            phase_next = rapf_pkg::PH_IDLE;
          end else if (is_write) begin
            phase_next = rapf_pkg::PH_WRITE;
          end else begin
            phase_next = rapf_pkg::PH_READ;
          end
        end
      end
      rapf_pkg::CMD_PAYLOAD: begin
        if (phase == rapf_pkg::PH_WRITE) begin
          bytes_left_next = bl_dec;
          if (bl_dec == 8'd0) begin
            phase_next = rapf_pkg::PH_IDLE;
          end
        end
      end
      rapf_pkg::CMD_RX: begin
        if (phase == rapf_pkg::PH_READ) begin
          bytes_left_next = bl_dec;
          if (bl_dec == 8'd0) begin
            phase_next = rapf_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  // Classification of the request into a job.
  always_comb begin
    q_job        = '0;
    q_job.op     = rapf_pkg::JOB_STATUS;
    q_job.status = rapf_pkg::ST_SEQ;
    q_job.hdr    = header_byte;
    q_job.uid    = request.unit_id;
    q_job.cnt    = request.byte_count;
    q_job.dat    = request.data_byte;
    q_job.addr   = request.reg_addr;
    if (is_start) begin
      if (phase != rapf_pkg::PH_IDLE) begin
        q_job.status = rapf_pkg::ST_SEQ;
      end else if (request.reg_addr[rapf_pkg::WR_BIT]) begin
        q_job.status = rapf_pkg::ST_ADDR;
      end else begin
        q_job.op                   = rapf_pkg::JOB_START;
        q_job.status               = rapf_pkg::ST_OK;
        q_job.flag                 = is_write && !cnt_zero;
        q_job.addr[rapf_pkg::WR_BIT] = is_write;
      end
    end else if (request.cmd == rapf_pkg::CMD_PAYLOAD) begin
      if (phase == rapf_pkg::PH_WRITE) begin
        q_job.op     = rapf_pkg::JOB_PAYLOAD;
        q_job.status = rapf_pkg::ST_OK;
        q_job.flag   = (bl_dec == 8'd0);
      end
    end else begin
      if (phase == rapf_pkg::PH_READ) begin
        q_job.op     = rapf_pkg::JOB_RDATA;
        q_job.status = rapf_pkg::ST_OK;
        q_job.flag   = (bl_dec == 8'd0);
      end
    end
  end

endmodule

>>> rtl/rapf_back.sv
// Back end: expands each job into its result items, keeps the running
// checksum and holds the result output register. Depends on rapf_pkg.
`include "register_access_packet_framer_defines.svh"

module rapf_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  rapf_pkg::job_t      q_job,
  output logic                q_rd,
  output logic                empty,
  input  logic                pop,
  output rapf_pkg::out_item_t result
);

  logic                 out_valid;
  rapf_pkg::out_item_t  item;
  logic [2:0]           step;
  logic [7:0]           running_sum;
  logic                 load;
  logic                 advance;
  logic                 final_item;
  logic                 sum_add;
  logic                 sum_clear;

  assign empty   = !out_valid;
  assign load    = !out_valid || pop;
  assign advance = q_valid && load;
  assign q_rd    = advance && final_item;

  // Result item for the current job and step.
  always_comb begin
    item       = '0;
    final_item = 1'b1;
    sum_add    = 1'b0;
    sum_clear  = 1'b0;
    case (q_job.op)
      rapf_pkg::JOB_STATUS: begin
        item.kind   = rapf_pkg::KIND_STATUS;
        item.status = q_job.status;
        item.last   = 1'b1;
      end
      rapf_pkg::JOB_START: begin
        item.kind  = rapf_pkg::KIND_TX;
        sum_add    = 1'b1;
        final_item = 1'b0;
        case (step)
          rapf_pkg::STEP_HDR: begin
            item.value = q_job.hdr;
            sum_clear  = 1'b1;
          end
          rapf_pkg::STEP_UID: begin
            item.value = q_job.uid;
          end
          rapf_pkg::STEP_ADDR: begin
            item.value = q_job.addr;
          end
          rapf_pkg::STEP_CNT: begin
            item.value = q_job.cnt;
            item.last  = q_job.flag;
            final_item = q_job.flag;
          end
          default: begin
            item.value = running_sum;
            item.last  = 1'b1;
            sum_add    = 1'b0;
            final_item = 1'b1;
          end
        endcase
      end
      rapf_pkg::JOB_PAYLOAD: begin
        item.kind = rapf_pkg::KIND_TX;
        if (step == rapf_pkg::STEP_HDR) begin
          item.value = q_job.dat;
          item.last  = !q_job.flag;
          final_item = !q_job.flag;
          sum_add    = 1'b1;
        end else begin
          item.value = running_sum;
          item.last  = 1'b1;
        end
      end
      default: begin
        item.kind  = rapf_pkg::KIND_READ;
        item.value = q_job.dat;
        item.last  = q_job.flag;
      end
    endcase
  end

  // Step counter within the job at the queue head.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= rapf_pkg::STEP_HDR;
    end else if (advance) begin
      step <= final_item ? rapf_pkg::STEP_HDR : step + 3'd1;
    end
  end

  // Running checksum of transmitted packet bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= 8'd0;
    end else if (advance && sum_add) begin
      running_sum <= (sum_clear ? 8'd0 : running_sum) + item.value;
    end
  end

  // Output register: refills whenever it is free or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= item;
    end
  end

  `RAPF_ASSERT_NOW(a_step_has_job, step != rapf_pkg::STEP_HDR, q_valid, "step set without a queued job")
  `RAPF_ASSERT_NOW(a_step_range, 1'b1, step <= rapf_pkg::STEP_SUM, "step beyond the sum byte")
  `RAPF_ASSERT_NOW(a_status_form, out_valid && result.kind == rapf_pkg::KIND_STATUS, result.last && result.value == 8'd0, "malformed status result")
  `RAPF_ASSERT_NEXT(a_held_result, out_valid && !pop, out_valid && $stable(result), "waiting result changed")

endmodule

>>> rtl/register_access_packet_framer.sv
// Top level of the register access packet framer.
// Depends on rapf_pkg, rapf_front, rapf_jobq and rapf_back.
//
// Master side of a byte-link register access protocol. Every request is
// taken by the front end and queued (four deep) as a job; the back end
// then emits that job's results one per cycle, while the output register
// is free or being popped, so a start yields four or five results
// (header, unit id, address, count, and the checksum where it is due), a
// final payload byte two, and every other request one. Requests keep being
// accepted while results wait, until the job queue fills. The header
// register must only be written while no request is in flight.
module register_access_packet_framer (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  rapf_pkg::in_item_t  request,
  output logic                empty,
  input  logic                pop,
  output rapf_pkg::out_item_t result,
  input  logic                header_we,
  input  logic [7:0]          header_wdata
);

  logic           q_wr;
  logic           q_full;
  rapf_pkg::job_t q_wr_job;
  logic           q_rd;
  logic           q_valid;
  rapf_pkg::job_t q_rd_job;
  logic           pop_ok;

  // A pop only counts while a result is on the ports.
  assign pop_ok = pop && !empty;

  rapf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .request      (request),
    .header_we    (header_we),
    .header_wdata (header_wdata),
    .q_wr         (q_wr),
    .q_job        (q_wr_job),
    .q_full       (q_full)
  );

  rapf_jobq u_jobq (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_wr),
    .wr_job   (q_wr_job),
    .full     (q_full),
    .rd_en    (q_rd),
    .rd_valid (q_valid),
    .rd_job   (q_rd_job)
  );

  rapf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_job   (q_rd_job),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop_ok),
    .result  (result)
  );

endmodule

>>> verif/tb_register_access_packet_framer.sv
// Self-checking testbench for the register access packet framer.
// Depends on rapf_pkg and register_access_packet_framer; a scoreboard class
// predicts every result from the accepted requests and checks them in order.
`timescale 1ns / 100ps

module tb_register_access_packet_framer;
  import rapf_pkg::*;

  // Predicts the framer's result stream and checks the observed results.
  class framer_scoreboard;
    logic [7:0] header;
    phase_t     phase;
    logic [7:0] sum;
    logic [7:0] bytes_left;
    out_item_t  pending_results[$];
    int         mismatches;

    function new();
      header     = HEADER_RESET;
      phase      = PH_IDLE;
      sum        = '0;
      bytes_left = '0;
      mismatches = 0;
    endfunction

    function void load_header(logic [7:0] v);
      header = v;
    endfunction

    function void add(logic [1:0] k, logic [7:0] v, logic [1:0] s, logic l);
      out_item_t e;
      e.kind   = k;
      e.value  = v;
      e.status = s;
      e.last   = l;
      pending_results.push_back(e);
    endfunction

    // A transmitted byte also goes into the running checksum.
    function void transmit(logic [7:0] b, logic l);
      add(KIND_TX, b, ST_OK, l);
      sum = sum + b;
    endfunction

    // Works out the results of one accepted request and updates the state.
    function void note_request(in_item_t r);
      logic [7:0] addr_out;
      case (r.cmd)
        CMD_WRITE, CMD_READ: begin
          if (phase != PH_IDLE) begin
            add(KIND_STATUS, 8'h00, ST_SEQ, 1'b1);
          end else if (r.reg_addr[WR_BIT]) begin
            add(KIND_STATUS, 8'h00, ST_ADDR, 1'b1);
          end else begin
            sum = '0;
            addr_out = r.reg_addr;
            if (r.cmd == CMD_WRITE) addr_out[WR_BIT] = 1'b1;
            transmit(header, 1'b0);
            transmit(r.unit_id, 1'b0);
            transmit(addr_out, 1'b0);
            if (r.cmd == CMD_WRITE && r.byte_count != 0) begin
              // The checksum follows the last payload byte instead.
              transmit(r.byte_count, 1'b1);
              phase = PH_WRITE;
            end else begin
              transmit(r.byte_count, 1'b0);
              add(KIND_TX, sum, ST_OK, 1'b1);
              phase = (r.byte_count != 0) ? PH_READ : PH_IDLE;
            end
            bytes_left = r.byte_count;
          end
        end
        CMD_PAYLOAD: begin
          if (phase != PH_WRITE) begin
            add(KIND_STATUS, 8'h00, ST_SEQ, 1'b1);
          end else begin
            bytes_left = bytes_left - 8'd1;
            if (bytes_left != 0) begin
              transmit(r.data_byte, 1'b1);
            end else begin
              transmit(r.data_byte, 1'b0);
              add(KIND_TX, sum, ST_OK, 1'b1);
              phase = PH_IDLE;
            end
          end
        end
        default: begin
          if (phase != PH_READ) begin
            add(KIND_STATUS, 8'h00, ST_SEQ, 1'b1);
          end else begin
            bytes_left = bytes_left - 8'd1;
            add(KIND_READ, r.data_byte, ST_OK, bytes_left == 0);
            if (bytes_left == 0) phase = PH_IDLE;
          end
        end
      endcase
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: kind %0d value %02h status %0d last %0b",
                   got.kind, got.value, got.status, got.last);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind || got.value !== want.value ||
          got.status !== want.status || got.last !== want.last) begin
        if (mismatches < 10)
          $display("mismatch: expected kind %0d value %02h status %0d last %0b, %s",
                   want.kind, want.value, want.status, want.last,
                   $sformatf("got kind %0d value %02h status %0d last %0b",
                             got.kind, got.value, got.status, got.last));
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  in_item_t    request = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   result;
  logic        header_we = 1'b0;
  logic [7:0]  header_wdata = 8'h00;

  framer_scoreboard sb = new();
  int unsigned      issued = 0;
  int unsigned      sender_idle_pct = 0;
  int unsigned      receiver_stall_pct = 0;
  int unsigned      hold_left = 0;

  register_access_packet_framer dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .request      (request),
    .empty        (empty),
    .pop          (pop),
    .result       (result),
    .header_we    (header_we),
    .header_wdata (header_wdata)
  );

  always #5 clk = ~clk;

  // Both handshakes are observed at the rising edge.
  always @(posedge clk) begin
    if (!rst && push && !full) sb.note_request(request);
    if (!rst && pop && !empty) sb.check_result(result);
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    do @(negedge clk); while (rst);
    forever begin
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= receiver_stall_pct);
      end
      @(negedge clk);
    end
  end

  // Safety net against a hung handshake.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic in_item_t make_request(logic [1:0] c, logic [7:0] u, logic [7:0] a,
                                            logic [7:0] n, logic [7:0] d);
    in_item_t r;
    r.cmd        = c;
    r.unit_id    = u;
    r.reg_addr   = a;
    r.byte_count = n;
    r.data_byte  = d;
    return r;
  endfunction

  // A request that is out of sequence for the current phase, or a start
  // with the address top bit set when the framer is idle.
  function automatic in_item_t stray_request();
    in_item_t r;
    r = make_request(2'($urandom_range(3)), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom));
    case (sb.phase)
      PH_IDLE: begin
        if (r.cmd == CMD_WRITE || r.cmd == CMD_READ) r.reg_addr[WR_BIT] = 1'b1;
      end
      PH_WRITE: begin
        if (r.cmd == CMD_PAYLOAD) r.cmd = CMD_RX;
      end
      default: begin
        if (r.cmd == CMD_RX) r.cmd = CMD_PAYLOAD;
      end
    endcase
    return r;
  endfunction

  function automatic int unsigned pick_count();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return 0;
    if (roll < 95) return $urandom_range(6, 1);
    return $urandom_range(20, 7);
  endfunction

  // Offers one request at the falling edge and holds it until accepted.
  task automatic send_request(input in_item_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    request <= r;
    do @(posedge clk); while (full);
    @(negedge clk);
    issued++;
  endtask

  // Stops offering requests until every expected result has come back.
  task automatic wait_for_results();
    push <= 1'b0;
    @(negedge clk);
    while (sb.pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_header(input logic [7:0] v);
    header_we    <= 1'b1;
    header_wdata <= v;
    @(negedge clk);
    header_we <= 1'b0;
    sb.load_header(v);
  endtask

  // One well-formed write or read, with an occasional stray request mixed in.
  task automatic run_transaction(input logic [1:0] start_cmd, input int unsigned n);
    logic [1:0] byte_cmd;
    byte_cmd = (start_cmd == CMD_WRITE) ? CMD_PAYLOAD : CMD_RX;
    send_request(make_request(start_cmd, 8'($urandom), 8'($urandom_range(127)),
                              8'(n), 8'($urandom)));
    repeat (n) begin
      if ($urandom_range(99) < 6) send_request(stray_request());
      send_request(make_request(byte_cmd, 8'($urandom), 8'($urandom), 8'($urandom),
                                8'($urandom)));
    end
  endtask

  task automatic random_phase(input int unsigned send_pct, input int unsigned stall_pct,
                              input int unsigned quota);
    int unsigned stop;
    stop = issued + quota;
    sender_idle_pct    = send_pct;
    receiver_stall_pct = stall_pct;
    while (issued < stop) begin
      if ($urandom_range(99) < 75)
        run_transaction($urandom_range(1) ? CMD_WRITE : CMD_READ, pick_count());
      else
        send_request(stray_request());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed requests with the header at its reset value.
    send_request(make_request(CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'hFF));
    send_request(make_request(CMD_RX, 8'hFF, 8'hFF, 8'hFF, 8'h00));
    send_request(make_request(CMD_WRITE, 8'hFF, 8'h80, 8'hFF, 8'h00));
    send_request(make_request(CMD_READ, 8'h00, 8'hFF, 8'h00, 8'hFF));
    // Zero count write and read send the whole packet at once.
    send_request(make_request(CMD_WRITE, 8'h00, 8'h00, 8'h00, 8'h00));
    send_request(make_request(CMD_READ, 8'hFF, 8'h7F, 8'h00, 8'h00));
    // Write of two bytes, with a start and a received byte out of sequence.
    send_request(make_request(CMD_WRITE, 8'h5A, 8'h7F, 8'h02, 8'h00));
    send_request(make_request(CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'hFF));
    send_request(make_request(CMD_READ, 8'h11, 8'h01, 8'h01, 8'h00));
    send_request(make_request(CMD_RX, 8'h00, 8'h00, 8'h00, 8'hA5));
    send_request(make_request(CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00));
    // Read of three bytes; the busy check wins over a bad address.
    send_request(make_request(CMD_READ, 8'h00, 8'h00, 8'h03, 8'h00));
    send_request(make_request(CMD_RX, 8'h00, 8'h00, 8'h00, 8'hFF));
    send_request(make_request(CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h3C));
    send_request(make_request(CMD_WRITE, 8'hFF, 8'h80, 8'h04, 8'h00));
    send_request(make_request(CMD_RX, 8'h00, 8'h00, 8'h00, 8'h00));
    send_request(make_request(CMD_RX, 8'h00, 8'h00, 8'h00, 8'h55));

    // No idling; the receiver first holds off so the framer fills up.
    wait_for_results();
    write_header(8'h00);
    hold_left = 80;
    random_phase(0, 0, 40);

    // Sender idles.
    wait_for_results();
    write_header(8'hFF);
    random_phase(48, 0, 40);

    // Receiver stalls.
    wait_for_results();
    write_header(8'($urandom));
    random_phase(0, 48, 40);

    // Both idle, after one long read.
    wait_for_results();
    write_header(8'($urandom));
    random_phase(21, 21, 0);
    run_transaction(CMD_READ, 40);
    random_phase(21, 21, 40);

    wait_for_results();
    repeat (20) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
